### rtl/dbl_pkg.sv
// Shared constants and types for the depth-buffer linearizer.
// No dependencies; used by every module under rtl/.
package dbl_pkg;

   localparam int DEPTH_FRAC_BITS = 24;
   localparam int CFG_W           = 32;
   localparam int SAMPLE_W        = DEPTH_FRAC_BITS + 1;
   localparam int OUT_W           = 40;
   // quotient never exceeds max(near, far), so it fits the register width
   localparam int Q_W             = CFG_W;
   localparam int NF_W            = 2 * CFG_W;
   localparam int NUM_W           = NF_W + DEPTH_FRAC_BITS;
   localparam int PROD_W          = CFG_W + DEPTH_FRAC_BITS;
   localparam int DEN_W           = PROD_W + 1;
   // two front stages, one stage per quotient bit, one output stage
   localparam int LATENCY         = 2 + Q_W + 1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR  = 1'b1;

   localparam logic [CFG_W-1:0] NEAR_RESET = 32'd655;
   localparam logic [CFG_W-1:0] FAR_RESET  = 32'd65536000;

   typedef struct packed {
      logic valid;
      logic infinite;
      logic zero;
   } ctrl_type;

   typedef struct packed {
      ctrl_type         ctrl;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [Q_W-1:0]   num_lo;
      logic [Q_W-1:0]   quot;
   } div_type;

endpackage

### rtl/dbl_front.sv
// Front end: products of the sample with near/far, then denominator and
// initial partial remainder for the bit-serial divider pipeline. Uses dbl_pkg.
module dbl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [dbl_pkg::SAMPLE_W-1:0]  sample,
   input  logic [dbl_pkg::CFG_W-1:0]     near_distance,
   input  logic [dbl_pkg::CFG_W-1:0]     far_distance,
   output dbl_pkg::div_type              div_out
);

   localparam int F = dbl_pkg::DEPTH_FRAC_BITS;

   // stage A: multipliers
   dbl_pkg::ctrl_type                a_ctrl_ff, a_ctrl_in;
   logic [dbl_pkg::NF_W-1:0]         a_nf_ff, a_nf_in;
   logic [dbl_pkg::PROD_W-1:0]       a_fs_ff, a_fs_in;
   logic [dbl_pkg::PROD_W-1:0]       a_sn_ff, a_sn_in;
   logic [F-1:0]                     comp;

   // stage B: denominator and starting remainder
   dbl_pkg::div_type                 b_ff, b_in;
   logic [dbl_pkg::NUM_W-1:0]        num;
   logic [dbl_pkg::DEN_W-1:0]        den;

   always_comb begin
      a_ctrl_in.valid    = in_valid;
      a_ctrl_in.infinite = sample[F];
      a_ctrl_in.zero     = (sample == '0);
      // 1.0 - d; meaningless for the zero and infinite cases, which are flagged
      comp    = F'(~sample[F-1:0] + 1'b1);
      a_nf_in = dbl_pkg::NF_W'(near_distance) * dbl_pkg::NF_W'(far_distance);
      a_fs_in = dbl_pkg::PROD_W'(far_distance) * dbl_pkg::PROD_W'(comp);
      a_sn_in = dbl_pkg::PROD_W'(near_distance) * dbl_pkg::PROD_W'(sample[F-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
      end else begin
         a_ctrl_ff <= a_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      a_nf_ff <= a_nf_in;
      a_fs_ff <= a_fs_in;
      a_sn_ff <= a_sn_in;
   end

   always_comb begin
      num = {a_nf_ff, {F{1'b0}}};
      den = dbl_pkg::DEN_W'(a_fs_ff) + dbl_pkg::DEN_W'(a_sn_ff);
      b_in.ctrl.valid    = a_ctrl_ff.valid;
      b_in.ctrl.infinite = a_ctrl_ff.infinite;
      // if 0 < d < 1.0, den is zero only for zero near and far; result is zero
      b_in.ctrl.zero     = a_ctrl_ff.zero | (den == '0);
      b_in.den           = den;
      // num >> Q_W is below den since the quotient fits Q_W bits
      b_in.rem           = dbl_pkg::DEN_W'(num[dbl_pkg::NUM_W-1:dbl_pkg::Q_W]);
      b_in.num_lo        = num[dbl_pkg::Q_W-1:0];
      b_in.quot          = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.ctrl <= '0;
      end else begin
         b_ff.ctrl <= b_in.ctrl;
      end
   end

   always_ff @(posedge clock) begin
      b_ff.den    <= b_in.den;
      b_ff.rem    <= b_in.rem;
      b_ff.num_lo <= b_in.num_lo;
      b_ff.quot   <= b_in.quot;
   end

   assign div_out = b_ff;

endmodule

### rtl/dbl_div_stage.sv
// One restoring-division step: brings down one numerator bit, compares and
// subtracts, shifts one quotient bit in. Registered. Uses dbl_pkg.
module dbl_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  dbl_pkg::div_type stage_in,
   output dbl_pkg::div_type stage_out
);

   dbl_pkg::div_type         stage_ff, stage_in_next;
   logic [dbl_pkg::DEN_W:0]  trial;
   logic [dbl_pkg::DEN_W:0]  diff;
   logic                     take;

   always_comb begin
      trial = {stage_in.rem, stage_in.num_lo[dbl_pkg::Q_W-1]};
      diff  = trial - {1'b0, stage_in.den};
      take  = (trial >= {1'b0, stage_in.den});
      stage_in_next.ctrl   = stage_in.ctrl;
      stage_in_next.den    = stage_in.den;
      stage_in_next.rem    = take ? diff[dbl_pkg::DEN_W-1:0] : trial[dbl_pkg::DEN_W-1:0];
      stage_in_next.num_lo = {stage_in.num_lo[dbl_pkg::Q_W-2:0], 1'b0};
      stage_in_next.quot   = {stage_in.quot[dbl_pkg::Q_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.ctrl <= '0;
      end else begin
         stage_ff.ctrl <= stage_in_next.ctrl;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.den    <= stage_in_next.den;
      stage_ff.rem    <= stage_in_next.rem;
      stage_ff.num_lo <= stage_in_next.num_lo;
      stage_ff.quot   <= stage_in_next.quot;
   end

   assign stage_out = stage_ff;

endmodule

### rtl/depth_buffer_linearize.sv
// Top level of the depth-buffer linearizer: CSRs, front end, divider chain
// and output register. Uses dbl_pkg, dbl_front, dbl_div_stage.
//
//   channel   handshake            payload
//   req       start / busy         req_depth_sample
//   rsp       rsp_valid (strobe)   rsp_linear_distance, rsp_is_infinite
//   csr       csr_valid/csr_ready  csr_index, csr_wdata
//
// One item per clock while busy is low; each result comes out after its item
// passes 2 multiply/add stages, 32 one-bit divider stages and 1 output stage.
// The divider chain does one compare/subtract per stage.
// Synchronous reset clears all valid bits and restores near/far; busy is held
// high and csr_ready low through reset and for the cycle after it.
// The result side never stalls; the pipeline has no backpressure.
module depth_buffer_linearize (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dbl_pkg::SAMPLE_W-1:0]      req_depth_sample,
   output logic                              rsp_valid,
   output logic [dbl_pkg::OUT_W-1:0]         rsp_linear_distance,
   output logic                              rsp_is_infinite,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dbl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dbl_pkg::CFG_W-1:0]         csr_wdata
);

   logic                           busy_ff;
   logic [dbl_pkg::CFG_W-1:0]      near_ff;
   logic [dbl_pkg::CFG_W-1:0]      far_ff;
   logic                           accept;
   logic                           csr_write;
   dbl_pkg::div_type               chain [dbl_pkg::Q_W+1];
   dbl_pkg::div_type               last;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [dbl_pkg::OUT_W-1:0]      rsp_dist_ff, rsp_dist_in;
   logic                           rsp_inf_ff, rsp_inf_in;

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;
   assign accept    = start & ~busy_ff;
   assign csr_write = csr_valid & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= dbl_pkg::NEAR_RESET;
         far_ff  <= dbl_pkg::FAR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            dbl_pkg::CSR_NEAR: near_ff <= csr_wdata;
            dbl_pkg::CSR_FAR:  far_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the user changes near/far only while idle; block does not enforce it
   dbl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .sample        (req_depth_sample),
      .near_distance (near_ff),
      .far_distance  (far_ff),
      .div_out       (chain[0])
   );

   for (genvar i = 0; i < dbl_pkg::Q_W; i++) begin : g_div
      dbl_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   assign last = chain[dbl_pkg::Q_W];

   always_comb begin
      rsp_valid_in = last.ctrl.valid;
      rsp_inf_in   = last.ctrl.infinite;
      if (last.ctrl.infinite || last.ctrl.zero) begin
         rsp_dist_in = '0;
      end else begin
         rsp_dist_in = {{(dbl_pkg::OUT_W-dbl_pkg::Q_W){1'b0}}, last.quot};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      rsp_inf_ff  <= rsp_inf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_linear_distance = rsp_dist_ff;
   assign rsp_is_infinite     = rsp_inf_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(dbl_pkg::LATENCY) rsp_valid)
      else $error("item did not come out after the pipeline latency");

   a_inf_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && req_depth_sample[dbl_pkg::DEPTH_FRAC_BITS])
         |-> ##(dbl_pkg::LATENCY) rsp_is_infinite)
      else $error("sample at or beyond 1.0 lost its infinity flag");

   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_infinite) |-> (rsp_linear_distance == '0))
      else $error("infinite result carries a nonzero distance");

   a_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_linear_distance[dbl_pkg::OUT_W-1:dbl_pkg::Q_W] == '0))
      else $error("distance exceeds quotient width");
`endif

endmodule

### dv/dbl_checker.sv
// Checker for the depth-buffer linearizer: watches the sample, result and CSR channels,
// predicts each linear distance and compares it with what the block returns.
// Depends on dbl_pkg for widths, CSR indexes and reset values.
`timescale 1ns / 1ps

module dbl_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [dbl_pkg::SAMPLE_W-1:0]   req_depth_sample,
   input  logic                           rsp_valid,
   input  logic [dbl_pkg::OUT_W-1:0]      rsp_linear_distance,
   input  logic                           rsp_is_infinite,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [dbl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbl_pkg::CFG_W-1:0]      csr_wdata,
   output int                             outstanding,
   output int                             fail_count,
   output int                             results_checked
);

   typedef struct packed {
      logic [dbl_pkg::OUT_W-1:0] distance;
      logic                      infinite;
   } depth_result_type;

   localparam logic [127:0] DEPTH_ONE_W = 128'd1 << dbl_pkg::DEPTH_FRAC_BITS;
   localparam logic [127:0] DIST_MAX_W  = (128'd1 << dbl_pkg::OUT_W) - 128'd1;

   logic [dbl_pkg::CFG_W-1:0] near_reg;
   logic [dbl_pkg::CFG_W-1:0] far_reg;
   depth_result_type          expected_distances [$];
   int                        mismatches = 0;
   int                        results_seen = 0;

   // exact n*f*2^F / (f*(2^F - s) + s*n), truncated and saturated
   function automatic depth_result_type linearize(
      input logic [dbl_pkg::SAMPLE_W-1:0] sample,
      input logic [dbl_pkg::CFG_W-1:0]    near_d,
      input logic [dbl_pkg::CFG_W-1:0]    far_d);
      depth_result_type res;
      logic [127:0]     s_w;
      logic [127:0]     numer;
      logic [127:0]     denom;
      logic [127:0]     quot;
      res   = '0;
      s_w   = 128'(sample);
      if (s_w >= DEPTH_ONE_W) begin
         res.infinite = 1'b1;
      end else if (s_w != 0) begin
         numer = (128'(near_d) * 128'(far_d)) << dbl_pkg::DEPTH_FRAC_BITS;
         denom = 128'(far_d) * (DEPTH_ONE_W - s_w) + s_w * 128'(near_d);
         if (denom != 0) begin
            quot = numer / denom;
            res.distance = (quot > DIST_MAX_W) ? DIST_MAX_W[dbl_pkg::OUT_W-1:0]
                                               : quot[dbl_pkg::OUT_W-1:0];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      depth_result_type want;
      if (reset) begin
         near_reg = dbl_pkg::NEAR_RESET;
         far_reg  = dbl_pkg::FAR_RESET;
         expected_distances.delete();
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (expected_distances.size() == 0) begin
               report_mismatch("result with no item outstanding",
                               64'(rsp_linear_distance), 64'(0));
            end else begin
               want = expected_distances.pop_front();
               if (rsp_linear_distance !== want.distance)
                  report_mismatch("linear_distance", 64'(rsp_linear_distance),
                                  64'(want.distance));
               if (rsp_is_infinite !== want.infinite)
                  report_mismatch("is_infinite", 64'(rsp_is_infinite), 64'(want.infinite));
            end
         end
         if (start && !busy)
            expected_distances.push_back(linearize(req_depth_sample, near_reg, far_reg));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dbl_pkg::CSR_NEAR: near_reg = csr_wdata;
               dbl_pkg::CSR_FAR:  far_reg  = csr_wdata;
               default:  ;
            endcase
         end
      end
      outstanding     <= expected_distances.size();
      fail_count      <= mismatches;
      results_checked <= results_seen;
   end

endmodule

### dv/tb.sv
// Top of the depth-buffer linearizer testbench: clock, reset, sample and CSR stimulus,
// watchdog and verdict. Instantiates depth_buffer_linearize and dbl_checker; uses dbl_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int          DEPTH_FRAC_BITS = dbl_pkg::DEPTH_FRAC_BITS;
   localparam int          SAMPLE_W        = dbl_pkg::SAMPLE_W;
   localparam int          OUT_W           = dbl_pkg::OUT_W;
   localparam int          CSR_IDX_W       = dbl_pkg::CSR_IDX_W;
   localparam int          CFG_W           = dbl_pkg::CFG_W;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          NUM_SETTINGS   = 8;
   localparam int          PHASE_ITEMS    = 155;
   localparam int unsigned DEPTH_ONE      = 1 << DEPTH_FRAC_BITS;
   localparam int unsigned SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [SAMPLE_W-1:0]   req_depth_sample = '0;
   logic                  rsp_valid;
   logic [OUT_W-1:0]      rsp_linear_distance;
   logic                  rsp_is_infinite;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = dbl_pkg::CSR_NEAR;
   logic [CFG_W-1:0]      csr_wdata = '0;

   int outstanding;
   int fail_count;
   int results_checked;
   int idle_cycles = 0;
   int samples_sent = 0;

   always #4 clock = ~clock;

   depth_buffer_linearize u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_depth_sample    (req_depth_sample),
      .rsp_valid           (rsp_valid),
      .rsp_linear_distance (rsp_linear_distance),
      .rsp_is_infinite     (rsp_is_infinite),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   dbl_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_depth_sample    (req_depth_sample),
      .rsp_valid           (rsp_valid),
      .rsp_linear_distance (rsp_linear_distance),
      .rsp_is_infinite     (rsp_is_infinite),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .outstanding         (outstanding),
      .fail_count          (fail_count),
      .results_checked     (results_checked)
   );

   // any accepted item, result or CSR write counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time, outstanding);
         $display("depth_buffer_linearize regression: fail");
         $finish;
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      start            <= 1'b1;
      req_depth_sample <= sample;
      do @(posedge clock); while (busy);
      samples_sent++;
   endtask

   task automatic pause_requests(input int cycles);
      start            <= 1'b0;
      req_depth_sample <= SAMPLE_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      repeat ($urandom_range(1, 4)) @(posedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_clip_range(input logic [CFG_W-1:0] near_d, input logic [CFG_W-1:0] far_d);
      if ($urandom_range(0, 1)) begin
         write_csr(dbl_pkg::CSR_NEAR, near_d);
         write_csr(dbl_pkg::CSR_FAR, far_d);
      end else begin
         write_csr(dbl_pkg::CSR_FAR, far_d);
         write_csr(dbl_pkg::CSR_NEAR, near_d);
      end
   endtask

   // mostly interior depths, with zero, beyond-one and both ends weighted in
   function automatic logic [SAMPLE_W-1:0] random_sample();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0:       return '0;
         1:       return SAMPLE_W'($urandom_range(DEPTH_ONE, SAMPLE_MAX));
         2:       return SAMPLE_W'($urandom_range(1, 15));
         3:       return SAMPLE_W'(DEPTH_ONE - $urandom_range(1, 16));
         4:       return SAMPLE_W'($urandom);
         default: return SAMPLE_W'($urandom_range(1, DEPTH_ONE - 1));
      endcase
   endfunction

   // idle_odds of 0 means back-to-back items
   task automatic run_random_samples(input int count, input int idle_odds);
      for (int i = 0; i < count; i++) begin
         if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            pause_requests($urandom_range(1, 9));
         send_sample(random_sample());
      end
   endtask

   initial begin
      logic [CFG_W-1:0] near_set [NUM_SETTINGS];
      logic [CFG_W-1:0] far_set  [NUM_SETTINGS];
      logic [SAMPLE_W-1:0] directed [$];

      // extremes, far below near, zero registers, then two random ranges
      near_set = '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                   32'd65536, 32'd0, 32'd0, 32'd0};
      far_set  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0,
                   32'd0, 32'd65536, 32'd0, 32'd0};
      near_set[6] = $urandom_range(1, 32'h00FF_FFFF);
      far_set[6]  = near_set[6] + $urandom_range(1, 32'h7FFF_FFFF);
      near_set[7] = $urandom;
      far_set[7]  = $urandom;

      directed = '{SAMPLE_W'(0), SAMPLE_W'(1), SAMPLE_W'(2), SAMPLE_W'(DEPTH_ONE / 2),
                   SAMPLE_W'(DEPTH_ONE - 2), SAMPLE_W'(DEPTH_ONE - 1),
                   SAMPLE_W'(DEPTH_ONE), SAMPLE_W'(DEPTH_ONE + 1), SAMPLE_W'(SAMPLE_MAX),
                   25'h0AA_AAAA, 25'h055_5555, 25'h155_5555, 25'h0FF_0000, 25'h000_FFFF};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset clip range first
      foreach (directed[i])
         send_sample(directed[i]);
      run_random_samples(PHASE_ITEMS, 4);

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         drain_pipeline();
         set_clip_range(near_set[p], far_set[p]);
         if (p == NUM_SETTINGS - 1)
            run_random_samples(PHASE_ITEMS, 0);
         else
            run_random_samples(PHASE_ITEMS, (p % 2 == 1) ? 3 : 10);
      end

      drain_pipeline();
      // catch any stray result after the last expected one
      repeat (dbl_pkg::LATENCY + 4) @(posedge clock);

      $display("Covered %0d depth samples under %0d near/far settings plus the reset range;",
               samples_sent, NUM_SETTINGS);
      $display("%0d results compared, %0d mismatches, %0d results missing.",
               results_checked, fail_count, outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("depth_buffer_linearize regression: pass");
      else
         $display("depth_buffer_linearize regression: fail");
      $finish;
   end

endmodule
